// ===== src/vector_matrix_multiply_macros.svh =====
// Assertion macros for the vector matrix multiply checker.
// Used by vmm_checker.sv; needs no other file.
`ifndef VECTOR_MATRIX_MULTIPLY_MACROS_SVH
`define VECTOR_MATRIX_MULTIPLY_MACROS_SVH

// same-cycle implication
`define VMM_ASSERT_NOW(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("vmm check failed");

// next-cycle implication
`define VMM_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("vmm check failed");

`endif

// ===== src/vmm_pkg.sv =====
// Shared types and constants for the vector matrix multiply block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vmm_pkg;

  localparam int ROW_W             = 4;
  localparam int DOT_W             = 36;
  localparam int CFG_W             = 5;
  localparam int QUEUE_DEPTH       = 2;
  localparam logic [CFG_W-1:0] ACTIVE_SIZE_RESET = 5'd16;

  typedef enum logic [0:0] {
    OP_WEIGHT = 1'b0,
    OP_VECTOR = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             start;
    logic             wr_en;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] column;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ISSUE,
    B_DRAIN
  } bstate_t;

endpackage

`default_nettype wire

// ===== src/vmm_front.sv =====
// Front end: accepts input items, range checks them and builds queue commands.
// Depends on vmm_pkg.
`default_nettype none

module vmm_front #(
  parameter int MAX_SIZE     = 16,
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           cmd,
  input  wire logic [vmm_pkg::ROW_W-1:0]      row,
  input  wire logic [vmm_pkg::ROW_W-1:0]      column,
  input  wire logic signed [ELEMENT_BITS-1:0] element_value,
  input  wire logic                           start_multiply,
  input  wire logic                           q_full,
  output logic                                push,
  output vmm_pkg::cmd_t                       push_cmd,
  output logic        [ELEMENT_BITS-1:0]      push_value
);

  logic row_ok;
  logic col_ok;

  assign row_ok   = 32'(row) < 32'(MAX_SIZE);
  assign col_ok   = 32'(column) < 32'(MAX_SIZE);
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_cmd.op     = vmm_pkg::op_t'(cmd);
    push_cmd.row    = row;
    push_cmd.column = column;
    push_cmd.start  = 1'b0;
    push_cmd.wr_en  = 1'b0;
    case (push_cmd.op)
      vmm_pkg::OP_WEIGHT: begin
        push_cmd.wr_en = row_ok && col_ok;
      end
      vmm_pkg::OP_VECTOR: begin
        push_cmd.wr_en = row_ok;
        push_cmd.start = start_multiply;
      end
      default: begin
        push_cmd.wr_en = 1'b0;
      end
    endcase
  end

  assign push_value = element_value;

endmodule

`default_nettype wire

// ===== src/vmm_queue.sv =====
// Short FIFO between the front end and the execution back end.
// Depends on vmm_pkg for its depth.
`default_nettype none

module vmm_queue #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int DEPTH = vmm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/vmm_back.sv =====
// Back end: executes queued loads into the matrix and vector memories and runs
// the column dot products through a multiply-accumulate pipeline. Uses vmm_pkg.
`default_nettype none

module vmm_back #(
  parameter int MAX_SIZE     = 16,
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [vmm_pkg::CFG_W-1:0]     size_cfg,
  input  wire logic                          q_empty,
  input  wire vmm_pkg::cmd_t                 q_cmd,
  input  wire logic [ELEMENT_BITS-1:0]       q_value,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [vmm_pkg::ROW_W-1:0]          column_index,
  output logic signed [vmm_pkg::DOT_W-1:0]   dot_value,
  output logic                               last_result
);

  localparam int RW     = vmm_pkg::ROW_W;
  localparam int DW     = vmm_pkg::DOT_W;
  localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int SIZE_W = $clog2(MAX_SIZE + 1);
  localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = 2 * ELEMENT_BITS;
  localparam int WIDE_W = (PROD_W > DW) ? PROD_W : DW;

  vmm_pkg::bstate_t state;
  vmm_pkg::bstate_t state_next;

  logic [ELEMENT_BITS-1:0] weight_mem [DEPTH];
  logic [ELEMENT_BITS-1:0] vector_mem [MAX_SIZE];

  logic [SIZE_W-1:0] n_eff;
  logic [SIZE_W-1:0] n_start;
  logic [IDX_W-1:0]  row_cnt;
  logic [IDX_W-1:0]  col_cnt;
  logic              row_last;
  logic              col_last;

  logic                           issue;
  logic                           w_we;
  logic                           v_we;
  logic                           pipe_busy;
  logic                           handoff;
  logic [ADDR_W-1:0]              w_waddr;
  logic [ADDR_W-1:0]              w_raddr;
  logic [IDX_W-1:0]               v_waddr;

  logic                           p1_valid;
  logic                           p1_first;
  logic                           p1_last;
  logic signed [ELEMENT_BITS-1:0] w_rd;
  logic signed [ELEMENT_BITS-1:0] v_rd;
  logic                           p2_valid;
  logic                           p2_first;
  logic                           p2_last;
  logic signed [PROD_W-1:0]       prod;
  logic signed [WIDE_W-1:0]       prod_wide;
  logic        [DW-1:0]           prod_dot;
  logic        [DW-1:0]           acc;
  logic                           acc_done;

  always_comb begin
    if (size_cfg == '0) begin
      n_start = SIZE_W'(1);
    end else if (32'(size_cfg) > 32'(MAX_SIZE)) begin
      n_start = SIZE_W'(MAX_SIZE);
    end else begin
      n_start = SIZE_W'(size_cfg);
    end
  end

  assign row_last  = SIZE_W'(row_cnt) == n_eff - SIZE_W'(1);
  assign col_last  = SIZE_W'(col_cnt) == n_eff - SIZE_W'(1);
  assign pipe_busy = p1_valid || p2_valid || acc_done;
  assign handoff   = acc_done && (!out_valid || out_ready);

  assign w_waddr = ADDR_W'(IDX_W'(q_cmd.row)) * ADDR_W'(MAX_SIZE) + ADDR_W'(IDX_W'(q_cmd.column));
  assign w_raddr = ADDR_W'(row_cnt) * ADDR_W'(MAX_SIZE) + ADDR_W'(col_cnt);
  assign v_waddr = IDX_W'(q_cmd.row);

  always_comb begin
    state_next = state;
    case (state)
      vmm_pkg::B_IDLE: begin
        if (!q_empty && q_cmd.start) begin
          state_next = vmm_pkg::B_ISSUE;
        end
      end
      vmm_pkg::B_ISSUE: begin
        if (row_last) begin
          state_next = vmm_pkg::B_DRAIN;
        end
      end
      vmm_pkg::B_DRAIN: begin
        if (!pipe_busy) begin
          state_next = col_last ? vmm_pkg::B_IDLE : vmm_pkg::B_ISSUE;
        end
      end
      default: begin
        state_next = vmm_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    issue = 1'b0;
    case (state)
      vmm_pkg::B_IDLE:  pop   = !q_empty;
      vmm_pkg::B_ISSUE: issue = 1'b1;
      default: begin
        pop   = 1'b0;
        issue = 1'b0;
      end
    endcase
  end

  assign w_we = pop && q_cmd.wr_en && (q_cmd.op == vmm_pkg::OP_WEIGHT);
  assign v_we = pop && q_cmd.wr_en && (q_cmd.op == vmm_pkg::OP_VECTOR);

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_waddr] <= q_value;
    end
    if (issue) begin
      w_rd <= weight_mem[w_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vector_mem[v_waddr] <= q_value;
    end
    if (issue) begin
      v_rd <= vector_mem[row_cnt];
    end
  end

  assign prod_wide = WIDE_W'(prod);
  assign prod_dot  = prod_wide[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vmm_pkg::B_IDLE;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      acc_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= issue;
      p2_valid <= p1_valid;
      if (handoff) begin
        acc_done  <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (p2_valid && p2_last) begin
        acc_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.start) begin
      n_eff   <= n_start;
      row_cnt <= '0;
      col_cnt <= '0;
    end
    if (issue) begin
      row_cnt <= row_last ? '0 : row_cnt + IDX_W'(1);
    end
    if ((state == vmm_pkg::B_DRAIN) && !pipe_busy && !col_last) begin
      col_cnt <= col_cnt + IDX_W'(1);
    end
    p1_first <= row_cnt == '0;
    p1_last  <= row_last;
    p2_first <= p1_first;
    p2_last  <= p1_last;
    prod     <= w_rd * v_rd;
    if (p2_valid) begin
      acc <= p2_first ? prod_dot : acc + prod_dot;
    end
    if (handoff) begin
      column_index <= RW'(col_cnt);
      dot_value    <= acc;
      last_result  <= col_last;
    end
  end

endmodule

`default_nettype wire

// ===== src/vector_matrix_multiply.sv =====
// Loads: one item per cycle through the front end and queue while the queue has room;
// the back end pops them while idle. Multiply: per column, n reads pass through the
// read, multiply and accumulate registers before the sum goes to the output register.
// Queue holds two items; the back end pops none while it runs the columns, so the input
// stalls once the queue is full. Reset clears control state and sets the stored size to 16;
// matrix and vector memories keep their contents and are undefined until written.
`default_nettype none

module vector_matrix_multiply #(
  parameter int MAX_SIZE     = 16,
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [vmm_pkg::CFG_W-1:0]       active_size,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            cmd,
  input  wire logic [vmm_pkg::ROW_W-1:0]       row,
  input  wire logic [vmm_pkg::ROW_W-1:0]       column,
  input  wire logic signed [ELEMENT_BITS-1:0]  element_value,
  input  wire logic                            start_multiply,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [vmm_pkg::ROW_W-1:0]            column_index,
  output logic signed [vmm_pkg::DOT_W-1:0]     dot_value,
  output logic                                 last_result
);

  localparam int QW = $bits(vmm_pkg::cmd_t) + ELEMENT_BITS;

  logic [vmm_pkg::CFG_W-1:0] size_cfg;
  logic                      push;
  vmm_pkg::cmd_t             push_cmd;
  logic [ELEMENT_BITS-1:0]   push_value;
  logic                      q_full;
  logic                      q_empty;
  logic                      pop;
  logic [QW-1:0]             q_rdata;
  vmm_pkg::cmd_t             q_cmd;
  logic [ELEMENT_BITS-1:0]   q_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= vmm_pkg::ACTIVE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_cfg <= active_size;
    end
  end

  vmm_front #(
    .MAX_SIZE     (MAX_SIZE),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .row            (row),
    .column         (column),
    .element_value  (element_value),
    .start_multiply (start_multiply),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd),
    .push_value     (push_value)
  );

  vmm_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_cmd, push_value}),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_cmd   = vmm_pkg::cmd_t'(q_rdata[QW-1:ELEMENT_BITS]);
  assign q_value = q_rdata[ELEMENT_BITS-1:0];

  vmm_back #(
    .MAX_SIZE     (MAX_SIZE),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .size_cfg     (size_cfg),
    .q_empty      (q_empty),
    .q_cmd        (q_cmd),
    .q_value      (q_value),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .column_index (column_index),
    .dot_value    (dot_value),
    .last_result  (last_result)
  );

endmodule

`default_nettype wire

// ===== src/vmm_checker.sv =====
// Port-level checks for vector_matrix_multiply, attached by bind.
// Depends on vmm_pkg and vector_matrix_multiply_macros.svh.
`default_nettype none
`include "vector_matrix_multiply_macros.svh"

module vmm_checker #(
  parameter int MAX_SIZE = 16
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready,
  input wire logic [vmm_pkg::CFG_W-1:0]        active_size,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             cmd,
  input wire logic                             start_multiply,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [vmm_pkg::ROW_W-1:0]        column_index,
  input wire logic signed [vmm_pkg::DOT_W-1:0] dot_value,
  input wire logic                             last_result
);

  localparam int RW = vmm_pkg::ROW_W;

  logic [vmm_pkg::CFG_W-1:0] size_seen;
  logic [RW-1:0]             exp_col;
  logic [RW-1:0]             last_col;
  logic                      seen_start;
  int                        eff;

  always_comb begin
    if (size_seen == '0) begin
      eff = 1;
    end else if (32'(size_seen) > 32'(MAX_SIZE)) begin
      eff = MAX_SIZE;
    end else begin
      eff = 32'(size_seen);
    end
    last_col = RW'(eff - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_seen  <= vmm_pkg::ACTIVE_SIZE_RESET;
      exp_col    <= '0;
      seen_start <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_seen <= active_size;
      end
      if (out_valid && out_ready) begin
        exp_col <= last_result ? '0 : exp_col + RW'(1);
      end
      if (in_valid && in_ready && cmd && start_multiply) begin
        seen_start <= 1'b1;
      end
    end
  end

  `VMM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(column_index) && $stable(dot_value) && $stable(last_result))
  `VMM_ASSERT_NOW(a_col_order, clk, rst, out_valid, column_index == exp_col)
  `VMM_ASSERT_NOW(a_last_col, clk, rst, out_valid && last_result, column_index == last_col)
  `VMM_ASSERT_NOW(a_no_spurious, clk, rst, out_valid, seen_start)

endmodule

bind vector_matrix_multiply vmm_checker #(
  .MAX_SIZE (MAX_SIZE)
) u_vmm_checker (.*);

`default_nettype wire
